// File: src/pbbq_pkg.sv
// ----------------------------------------------------------------------------
// pbbq_pkg
// Shared types and constants of the priority byte budget queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbbq_pkg;

  // envelope added to every payload
  localparam logic [16:0] ENV_BYTES = 17'd64;

  // command codes
  localparam logic [1:0] CMD_ENQ   = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_DONE  = 2'd2;

  // result status codes
  localparam logic [3:0] ST_QUEUED    = 4'd0;
  localparam logic [3:0] ST_DROP_TTL  = 4'd1;
  localparam logic [3:0] ST_DROP_BIG  = 4'd2;
  localparam logic [3:0] ST_DROP_FULL = 4'd3;
  localparam logic [3:0] ST_EVICTED   = 4'd4;
  localparam logic [3:0] ST_STARTED   = 4'd5;
  localparam logic [3:0] ST_DELIVERED = 4'd6;
  localparam logic [3:0] ST_RETRY     = 4'd7;
  localparam logic [3:0] ST_DROP_ERR  = 4'd8;
  localparam logic [3:0] ST_IDLE      = 4'd9;

  // configuration register indexes
  localparam logic CFG_CAPACITY = 1'b0;
  localparam logic CFG_RETRY    = 1'b1;

  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] tag;
    logic [7:0]  priority_req;
    logic [15:0] payload_len;
    logic        reliable;
    logic        expired;
    logic        failed;
  } pbbq_in_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [15:0] out_tag;
    logic [16:0] out_bytes;
    logic [4:0]  queued_count;
    logic [23:0] held_bytes;
    logic        last;
  } pbbq_out_t;

  // one queue entry as held in a cell
  typedef struct packed {
    logic [15:0] tag;
    logic [7:0]  prio;
    logic [16:0] bytes;
    logic        reliable;
    logic [3:0]  attempts;
    logic        mark;
  } pbbq_entry_t;

  typedef enum logic [2:0] {
    OP_HOLD, OP_UP, OP_DOWN, OP_NEW, OP_MARK, OP_RETRY
  } pbbq_op_t;

  typedef struct packed {
    pbbq_op_t op;
  } pbbq_ctl_t;

endpackage

// File: src/pbbq_cell.sv
// ----------------------------------------------------------------------------
// pbbq_cell
// One queue slot; loads from its upper or lower neighbor, the new packet,
// or updates its own mark and attempt count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbbq_cell
  import pbbq_pkg::*;
(
  input  logic        clk,
  input  pbbq_ctl_t   ctl,
  input  pbbq_entry_t up_entry,
  input  pbbq_entry_t dn_entry,
  input  pbbq_entry_t new_entry,
  output pbbq_entry_t entry
);

  // slot update
  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_UP:    entry <= up_entry;
      OP_DOWN:  entry <= dn_entry;
      OP_NEW:   entry <= new_entry;
      OP_MARK:  entry.mark <= 1'b1;
      OP_RETRY: entry.attempts <= entry.attempts + 4'd1;
      default:  entry <= entry;
    endcase
  end

endmodule

// File: src/priority_byte_budget_queue.sv
// ----------------------------------------------------------------------------
// priority_byte_budget_queue
// Priority ordered packet queue with a byte budget, kept in a row of cells.
// ----------------------------------------------------------------------------
// Enqueue: accepted, then eviction search in S_EVICT and results in S_EMIT;
//   E evictions first, then the final result, one result per cycle.
// Start / complete / unknown: one result, registered in S_CMD after accept.
// Next transaction is taken in the cycle the last result is shown, set by the
//   one-victim-per-cycle search and one-removal-per-cycle shift of the cells.
// Reset clears state, count, bytes and sets config defaults; slots unwritten.
`timescale 1ns / 1ps

module priority_byte_budget_queue
  import pbbq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  pbbq_in_t    request,
  output logic        result_valid,
  output pbbq_out_t   result,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {S_IDLE, S_EVICT, S_EMIT, S_CMD} state_t;

  state_t      state;
  pbbq_in_t    req;
  logic [23:0] capacity;
  logic [3:0]  retry_limit;
  logic        inflight;
  logic [CW-1:0] count;
  logic [CW-1:0] pend;
  logic [23:0] total;
  logic [3:0]  outcome;

  pbbq_entry_t ent [DEPTH];
  pbbq_ctl_t   ctl [DEPTH];
  pbbq_entry_t new_entry;

  logic [DEPTH-1:0] valid, cand, vsel, stop, bef, mk, rsel, rge, above, mabove;

  logic [16:0] new_bytes;
  logic [CW-1:0] live_cnt;
  logic        need;
  logic        too_big;
  logic        vfound;
  logic [16:0] vbytes;
  logic [15:0] rtag;
  logic [16:0] rbytes;
  logic        qadd;

  // cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    pbbq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl[i]),
      .up_entry  (ent[(i < DEPTH - 1) ? i + 1 : i]),
      .dn_entry  (ent[(i > 0) ? i - 1 : i]),
      .new_entry (new_entry),
      .entry     (ent[i])
    );
  end

  assign new_bytes = {1'b0, req.payload_len} + ENV_BYTES;
  assign live_cnt  = count - pend;
  assign need      = (live_cnt >= CW'(DEPTH)) ||
                     (({1'b0, total} + {8'd0, new_bytes}) > {1'b0, capacity});
  assign too_big   = {7'd0, new_bytes} > capacity;
  assign qadd      = (outcome == ST_QUEUED);

  assign new_entry = '{tag: req.tag, prio: req.priority_req, bytes: new_bytes,
                       reliable: req.reliable, attempts: 4'd0, mark: 1'b0};

  // per-cell flags and the neighbor chains
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      valid[i] = CW'(i) < count;
      stop[i]  = valid[i] && (ent[i].prio < req.priority_req) && !(i == 0 && inflight);
      cand[i]  = stop[i] && !ent[i].mark;
      mk[i]    = valid[i] && ent[i].mark;
    end
    above[DEPTH-1]  = 1'b0;
    mabove[DEPTH-1] = 1'b0;
    for (int i = DEPTH - 2; i >= 0; i--) begin
      above[i]  = above[i+1] | cand[i+1];
      mabove[i] = mabove[i+1] | mk[i+1];
    end
    bef[0] = 1'b0;
    for (int i = 1; i < DEPTH; i++) bef[i] = bef[i-1] | stop[i-1];
    vsel = cand & ~above;
    rsel = mk & ~mabove;
    rge[0] = rsel[0];
    for (int i = 1; i < DEPTH; i++) rge[i] = rge[i-1] | rsel[i];
    vfound = |cand;
    vbytes = '0;
    rtag   = '0;
    rbytes = '0;
    for (int i = 0; i < DEPTH; i++) begin
      vbytes = vbytes | (ent[i].bytes & {17{vsel[i]}});
      rtag   = rtag   | (ent[i].tag   & {16{rsel[i]}});
      rbytes = rbytes | (ent[i].bytes & {17{rsel[i]}});
    end
  end

  // cell operations
  always_comb begin
    for (int i = 0; i < DEPTH; i++) ctl[i].op = OP_HOLD;
    unique case (state)
      S_EVICT: begin
        if (!req.expired && !too_big && need && vfound)
          for (int i = 0; i < DEPTH; i++) if (vsel[i]) ctl[i].op = OP_MARK;
      end
      S_EMIT: begin
        if (pend != '0) begin
          for (int i = 0; i < DEPTH; i++) if (rge[i]) ctl[i].op = OP_UP;
        end else if (qadd) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (bef[i]) ctl[i].op = OP_DOWN;
            else if (stop[i] || CW'(i) == count) ctl[i].op = OP_NEW;
          end
        end
      end
      S_CMD: begin
        if (req.command == CMD_DONE && count != '0 && inflight) begin
          if (req.failed && ent[0].reliable && ent[0].attempts < retry_limit)
            ctl[0].op = OP_RETRY;
          else
            for (int i = 0; i < DEPTH; i++) ctl[i].op = OP_UP;
        end
      end
      default: ;
    endcase
  end

  assign busy = (state != S_IDLE);

  // sequencer, counters and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      capacity     <= 24'd262144;
      retry_limit  <= 4'd3;
      inflight     <= 1'b0;
      count        <= '0;
      pend         <= '0;
      total        <= '0;
      outcome      <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      // configuration writes
      if (cfg_we) begin
        if (cfg_index == CFG_CAPACITY) capacity <= cfg_data;
        else retry_limit <= cfg_data[3:0];
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req   <= request;
            pend  <= '0;
            state <= (request.command == CMD_ENQ) ? S_EVICT : S_CMD;
          end
        end
        S_EVICT: begin
          // one victim per cycle, nearest the tail first
          if (req.expired) begin
            outcome <= ST_DROP_TTL;
            state   <= S_EMIT;
          end else if (too_big) begin
            outcome <= ST_DROP_BIG;
            state   <= S_EMIT;
          end else if (need) begin
            if (vfound) begin
              total <= total - (({7'd0, vbytes} >= total) ? total : {7'd0, vbytes});
              pend  <= pend + CW'(1);
            end else begin
              outcome <= ST_DROP_FULL;
              state   <= S_EMIT;
            end
          end else begin
            outcome <= ST_QUEUED;
            state   <= S_EMIT;
          end
        end
        S_EMIT: begin
          result_valid <= 1'b1;
          result.queued_count <= 5'(count - pend + CW'(qadd));
          result.held_bytes   <= total + (qadd ? {7'd0, new_bytes} : 24'd0);
          if (pend != '0) begin
            // evicted transaction, slot removed by shifting down
            result.status    <= ST_EVICTED;
            result.out_tag   <= rtag;
            result.out_bytes <= rbytes;
            result.last      <= 1'b0;
            count <= count - CW'(1);
            pend  <= pend - CW'(1);
          end else begin
            result.status    <= outcome;
            result.out_tag   <= req.tag;
            result.out_bytes <= new_bytes;
            result.last      <= 1'b1;
            if (qadd) begin
              count <= count + CW'(1);
              total <= total + {7'd0, new_bytes};
            end
            state <= S_IDLE;
          end
        end
        S_CMD: begin
          result_valid        <= 1'b1;
          result.last         <= 1'b1;
          result.status       <= ST_IDLE;
          result.out_tag      <= '0;
          result.out_bytes    <= '0;
          result.queued_count <= 5'(count);
          result.held_bytes   <= total;
          if (req.command == CMD_START && count != '0) begin
            inflight         <= 1'b1;
            result.status    <= ST_STARTED;
            result.out_tag   <= ent[0].tag;
            result.out_bytes <= ent[0].bytes;
          end else if (req.command == CMD_DONE && count != '0 && inflight) begin
            result.out_tag   <= ent[0].tag;
            result.out_bytes <= ent[0].bytes;
            inflight         <= 1'b0;
            if (req.failed && ent[0].reliable && ent[0].attempts < retry_limit) begin
              result.status <= ST_RETRY;
            end else begin
              result.status       <= req.failed ? ST_DROP_ERR : ST_DELIVERED;
              count               <= count - CW'(1);
              result.queued_count <= 5'(count - CW'(1));
              total <= total - (({7'd0, ent[0].bytes} >= total) ? total
                                                                 : {7'd0, ent[0].bytes});
              result.held_bytes <= total - (({7'd0, ent[0].bytes} >= total) ? total
                                                                 : {7'd0, ent[0].bytes});
            end
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  a_nonlast_evicted: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.last |-> result.status == ST_EVICTED)
    else $error("non-final result is not an eviction");
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    !busy |-> pend == '0)
    else $error("pending evictions while idle");
  a_inflight_nonempty: assert property (@(posedge clk) disable iff (rst)
    inflight |-> count != '0)
    else $error("in-flight mark on empty queue");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count beyond depth");

endmodule
